// ----- rtl/dsgc_pkg.sv -----
// ----------------------------------------------------------------------------
// dsgc_pkg
// Shared types and constants of the degree sequence graphic check.
// ----------------------------------------------------------------------------
`default_nettype none

package dsgc_pkg;

  localparam int DEGREE_W       = 6;
  localparam int NUM_VERTICES_W = 7;
  localparam int VERDICT_W      = 2;

  localparam logic [NUM_VERTICES_W-1:0] NUM_VERTICES_RST = 7'd4;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_OK   = 2'd0,
    VERDICT_ASYM = 2'd1,
    VERDICT_ODD  = 2'd2,
    VERDICT_EG   = 2'd3
  } verdict_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // store the incoming degree and its prefix sum
    logic sym_start;  // i <= 0
    logic sym_next;   // i <= i + 1
    logic eg_start;   // k <= 1
    logic eg_init;    // acc <= k(k-1), i <= k
    logic eg_add;     // acc += min(d[i], k), i <= i + 1
    logic k_next;     // k <= k + 1
    logic finish;     // clear running sum
  } dsgc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;     // this word completes the sequence
    logic sym_ok;   // d[i] + d[N-1-i] == N-1
    logic sym_end;  // i == N-1
    logic sum_odd;
    logic i_end;    // i >= N
    logic eg_fail;  // prefix(k) > right side
    logic k_end;    // k == N
  } dsgc_status_t;

endpackage

`default_nettype wire

// ----- rtl/dsgc_stream_if.sv -----
// ----------------------------------------------------------------------------
// dsgc_stream_if
// Valid/ready channels carrying degree words in and verdict words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface dsgc_degree_if import dsgc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DEGREE_W-1:0] degree;

  modport source (output valid, output degree, input ready);
  modport sink   (input valid, input degree, output ready);
endinterface

interface dsgc_verdict_if import dsgc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [VERDICT_W-1:0] verdict;

  modport source (output valid, output verdict, input ready);
  modport sink   (input valid, input verdict, output ready);
endinterface

`default_nettype wire

// ----- rtl/dsgc_datapath.sv -----
// ----------------------------------------------------------------------------
// dsgc_datapath
// Degree and prefix-sum memories, length register, index counters and the
// right-side accumulator of the Erdos-Gallai check.
// ----------------------------------------------------------------------------
`default_nettype none

module dsgc_datapath import dsgc_pkg::*; #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [NUM_VERTICES_W-1:0] cfg_wdata,
  input  logic [DEGREE_W-1:0]       degree,
  input  dsgc_cmd_t                 cmd,
  output dsgc_status_t              status
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int SW = $clog2(MAX_VERTICES * 63 + 1);
  localparam int RW = $clog2(MAX_VERTICES * MAX_VERTICES + MAX_VERTICES * 64 + 1);
  localparam int NW = (CW > NUM_VERTICES_W) ? CW : NUM_VERTICES_W;
  localparam int MW = (CW > DEGREE_W) ? CW : DEGREE_W;
  localparam int XW = (CW > DEGREE_W + 1) ? CW : DEGREE_W + 1;

  logic [NUM_VERTICES_W-1:0] num_vertices;
  logic [CW-1:0]             pos;
  logic [SW-1:0]             running_sum;
  logic [CW-1:0]             i;
  logic [CW-1:0]             k;
  logic [RW-1:0]             acc;

  logic [DEGREE_W-1:0] deg_mem    [MAX_VERTICES];
  logic [SW-1:0]       prefix_mem [MAX_VERTICES];
  logic [DEGREE_W-1:0] rd_a;
  logic [DEGREE_W-1:0] rd_b;
  logic [SW-1:0]       rd_p;

  logic [NW-1:0] nv_ext;
  logic [CW-1:0] n_eff;
  logic [CW-1:0] n_m1;
  logic [CW-1:0] pos_eff;
  logic [CW-1:0] km1;
  logic [CW-1:0] mirror;
  logic [SW-1:0] sum_next;
  logic [MW-1:0] cap;
  logic [XW-1:0] pair_sum;

  always_comb begin
    nv_ext = NW'(num_vertices);
    if (nv_ext == '0) begin
      n_eff = CW'(1);
    end else if (nv_ext > NW'(MAX_VERTICES)) begin
      n_eff = CW'(MAX_VERTICES);
    end else begin
      n_eff = CW'(nv_ext);
    end
    n_m1     = n_eff - CW'(1);
    pos_eff  = (pos >= n_eff) ? '0 : pos;
    km1      = k - CW'(1);
    mirror   = n_m1 - i;
    sum_next = running_sum + SW'(degree);
    cap      = (MW'(rd_a) < MW'(k)) ? MW'(rd_a) : MW'(k);
    pair_sum = XW'(rd_a) + XW'(rd_b);
  end

  always_comb begin
    status.last    = (pos_eff == n_m1);
    status.sym_ok  = (pair_sum == XW'(n_m1));
    status.sym_end = (i == n_m1);
    status.sum_odd = running_sum[0];
    status.i_end   = (i >= n_eff);
    status.eg_fail = (RW'(rd_p) > acc);
    status.k_end   = (k == n_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_vertices <= NUM_VERTICES_RST;
      pos          <= '0;
      running_sum  <= '0;
    end else if (cfg_we) begin
      num_vertices <= cfg_wdata;
      pos          <= '0;
      running_sum  <= '0;
    end else begin
      if (cmd.load) begin
        running_sum <= sum_next;
        pos         <= status.last ? '0 : pos_eff + CW'(1);
      end
      if (cmd.finish) begin
        running_sum <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sym_start) begin
      i <= '0;
    end
    if (cmd.sym_next) begin
      i <= i + CW'(1);
    end
    if (cmd.eg_start) begin
      k <= CW'(1);
    end
    if (cmd.eg_init) begin
      acc <= RW'(k) * RW'(km1);
      i   <= k;
    end
    if (cmd.eg_add) begin
      acc <= acc + RW'(cap);
      i   <= i + CW'(1);
    end
    if (cmd.k_next) begin
      k <= k + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      deg_mem[pos_eff[AW-1:0]]    <= degree;
      prefix_mem[pos_eff[AW-1:0]] <= sum_next;
    end
    rd_a <= deg_mem[i[AW-1:0]];
    rd_b <= deg_mem[mirror[AW-1:0]];
    rd_p <= prefix_mem[km1[AW-1:0]];
  end

endmodule

`default_nettype wire

// ----- rtl/dsgc_controller.sv -----
// ----------------------------------------------------------------------------
// dsgc_controller
// Sequences loading, the symmetry scan, the parity test and the Erdos-Gallai
// scan; holds the verdict output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dsgc_controller import dsgc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  output verdict_t     verdict,
  output dsgc_cmd_t    cmd,
  input  dsgc_status_t status
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SYM_RD,
    S_SYM_CMP,
    S_PARITY,
    S_EG_INIT,
    S_EG_RD,
    S_EG_ADD,
    S_EG_CMP,
    S_EMIT
  } state_t;

  state_t   state;
  verdict_t result;
  logic     out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.load      = in_valid;
        cmd.sym_start = in_valid && status.last;
      end
      S_SYM_CMP: begin
        cmd.sym_next = status.sym_ok && !status.sym_end;
      end
      S_PARITY: begin
        cmd.eg_start = !status.sum_odd;
      end
      S_EG_INIT: begin
        cmd.eg_init = 1'b1;
      end
      S_EG_ADD: begin
        cmd.eg_add = 1'b1;
      end
      S_EG_CMP: begin
        cmd.k_next = !status.eg_fail && !status.k_end;
      end
      S_EMIT: begin
        cmd.finish = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      result    <= VERDICT_OK;
      verdict   <= VERDICT_OK;
    end else begin
      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && status.last) begin
            state <= S_SYM_RD;
          end
        end
        S_SYM_RD: begin
          state <= S_SYM_CMP;
        end
        S_SYM_CMP: begin
          if (!status.sym_ok) begin
            result <= VERDICT_ASYM;
            state  <= S_EMIT;
          end else if (status.sym_end) begin
            state <= S_PARITY;
          end else begin
            state <= S_SYM_RD;
          end
        end
        S_PARITY: begin
          if (status.sum_odd) begin
            result <= VERDICT_ODD;
            state  <= S_EMIT;
          end else begin
            state <= S_EG_INIT;
          end
        end
        S_EG_INIT: begin
          state <= S_EG_RD;
        end
        S_EG_RD: begin
          state <= status.i_end ? S_EG_CMP : S_EG_ADD;
        end
        S_EG_ADD: begin
          state <= S_EG_RD;
        end
        S_EG_CMP: begin
          if (status.eg_fail) begin
            result <= VERDICT_EG;
            state  <= S_EMIT;
          end else if (status.k_end) begin
            result <= VERDICT_OK;
            state  <= S_EMIT;
          end else begin
            state <= S_EG_INIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            verdict <= result;
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/degree_sequence_graphic_check.sv -----
// ----------------------------------------------------------------------------
// degree_sequence_graphic_check
// Erdos-Gallai graphic sequence test with a complement symmetry precondition.
//
// degrees : valid/ready sink, one 6-bit degree per word. N = cfg length,
//           saturated into 1..MAX_VERTICES.
// verdicts: valid/ready source, one 2-bit verdict per N degree words:
//           ok, not complement-symmetric, odd sum, inequality violated.
// cfg_we/cfg_wdata write the sequence length and drop a partial sequence.
// Degree words load at one per cycle while the controller is idle. After
// the last one the check runs: the symmetry scan reads and compares each
// vertex, the parity test follows, and the inequality for each k sets up
// k(k-1), adds min(d[i], k) for each i from k up and then compares; the
// verdict then moves to the output register. All scans step through the
// degree memory one entry at a time with a registered read in between, and
// the check ends early when one of its tests fails.
// The verdict sits in an output register; the next sequence loads while it
// waits. A new verdict waits in the controller until that register frees.
// Reset (rst, synchronous) sets the length to 4, empties the partial
// sequence and drops a pending verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module degree_sequence_graphic_check import dsgc_pkg::*; #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [NUM_VERTICES_W-1:0] cfg_wdata,
  dsgc_degree_if.sink               degrees,
  dsgc_verdict_if.source            verdicts
);

  dsgc_cmd_t    cmd;
  dsgc_status_t status;
  logic         in_ready;
  logic         out_valid;
  verdict_t     verdict;

  dsgc_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (degrees.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (verdicts.ready),
    .verdict   (verdict),
    .cmd       (cmd),
    .status    (status)
  );

  dsgc_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .degree    (degrees.degree),
    .cmd       (cmd),
    .status    (status)
  );

  assign degrees.ready    = in_ready;
  assign verdicts.valid   = out_valid;
  assign verdicts.verdict = verdict;

endmodule

`default_nettype wire

// ----- rtl/dsgc_checker.sv -----
// ----------------------------------------------------------------------------
// dsgc_checker
// Port-level checks of the degree sequence graphic check, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module dsgc_checker import dsgc_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [VERDICT_W-1:0] verdict
);

  // reset drops any pending verdict
  a_rst_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("verdict valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(verdict))
    else $error("stalled verdict word changed");

  // a verdict is only produced after a check phase with input closed
  a_verdict_after_check: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("verdict appeared without a check phase");

  // input closes only after taking a word
  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(in_valid))
    else $error("input closed without an accepted word");

endmodule

bind degree_sequence_graphic_check dsgc_checker u_dsgc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (degrees.valid),
  .in_ready  (degrees.ready),
  .out_valid (verdicts.valid),
  .out_ready (verdicts.ready),
  .verdict   (verdicts.verdict)
);

`default_nettype wire

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Testbench of degree_sequence_graphic_check. Degree words go in through a
// valid/ready channel and are replayed into a scoreboard class that
// predicts one verdict per completed sequence. Each verdict word that comes
// out is checked in order against that prediction. A short directed part
// covers every verdict, the reset length, extreme degrees and a dropped
// partial sequence. Random sequences follow, mostly well formed (sorted and
// complement-symmetric), with unsorted, damaged and noise sequences among
// them. Lengths go through zero, one, the maximum and values above it.
// Sender and receiver stall at random. Once the receiver holds off for a
// long stretch so that the block fills up.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import dsgc_pkg::*;

  localparam int MAX_VERTICES  = 64;
  localparam int QUIET_LIMIT   = 20000;
  localparam int RANDOM_ITEMS  = 850;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 500;

  typedef enum {SHAPE_SORTED, SHAPE_MIRRORED, SHAPE_DAMAGED, SHAPE_NOISE} seq_shape_t;

  class verdict_board;
    int unsigned length_reg;
    int unsigned degree_mem[MAX_VERTICES];
    int unsigned prefix_mem[MAX_VERTICES];
    int unsigned loaded;
    int unsigned running_sum;
    verdict_t    verdicts_due[$];
    int          errors;

    function new();
      length_reg  = 32'(NUM_VERTICES_RST);
      loaded      = 0;
      running_sum = 0;
      errors      = 0;
    endfunction

    function int unsigned sequence_length();
      if (length_reg < 1) return 1;
      if (length_reg > MAX_VERTICES) return MAX_VERTICES;
      return length_reg;
    endfunction

    // a length write drops any partial sequence
    function void set_length(logic [NUM_VERTICES_W-1:0] value);
      length_reg  = 32'(value);
      loaded      = 0;
      running_sum = 0;
    endfunction

    function verdict_t graphic_verdict(int unsigned n);
      int unsigned rhs;
      for (int unsigned i = 0; i < n; i++) begin
        if (degree_mem[i] + degree_mem[n - 1 - i] != n - 1) return VERDICT_ASYM;
      end
      if (running_sum[0]) return VERDICT_ODD;
      for (int unsigned k = 1; k <= n; k++) begin
        rhs = k * (k - 1);
        for (int unsigned i = k; i < n; i++) begin
          rhs += (degree_mem[i] < k) ? degree_mem[i] : k;
        end
        if (prefix_mem[k - 1] > rhs) return VERDICT_EG;
      end
      return VERDICT_OK;
    endfunction

    function void note_degree(logic [DEGREE_W-1:0] degree);
      int unsigned n;
      verdict_t    due;
      n = sequence_length();
      degree_mem[loaded] = 32'(degree);
      running_sum += 32'(degree);
      prefix_mem[loaded] = running_sum;
      loaded++;
      if (loaded >= n) begin
        due          = graphic_verdict(n);
        verdicts_due = {verdicts_due, due};
        loaded       = 0;
        running_sum  = 0;
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 50) $display("%0t: mismatch: %s", $time, msg);
    endtask

    task check_verdict(logic [VERDICT_W-1:0] got);
      verdict_t want;
      if (verdicts_due.size() == 0) begin
        report_mismatch($sformatf("verdict %0d with none expected", got));
        return;
      end
      want = verdicts_due.pop_front();
      if (got !== want)
        report_mismatch($sformatf("verdict %0d, expected %s", got, want.name()));
    endtask
  endclass

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [NUM_VERTICES_W-1:0] cfg_wdata;
  int                        tx_idle_pct = 0;
  int                        rx_idle_pct = 0;
  int                        hold_requests = 0;
  int                        quiet_cycles = 0;
  logic [DEGREE_W-1:0]       seq_buf[MAX_VERTICES];
  verdict_board              board = new();

  dsgc_degree_if  degree_ch ();
  dsgc_verdict_if verdict_ch ();

  degree_sequence_graphic_check #(
    .MAX_VERTICES(MAX_VERTICES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .degrees  (degree_ch),
    .verdicts (verdict_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // watchdog: cycles without any accepted word
  always @(posedge clk) begin
    if (rst || (degree_ch.valid && degree_ch.ready) ||
        (verdict_ch.valid && verdict_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : verdict_sink
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    verdict_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && verdict_ch.valid && verdict_ch.ready) board.check_verdict(verdict_ch.verdict);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        verdict_ch.ready <= 1'b0;
      end else begin
        verdict_ch.ready <= (int'($urandom_range(0, 99)) >= rx_idle_pct);
      end
    end
  end

  task automatic send_degree(input logic [DEGREE_W-1:0] degree);
    while (int'($urandom_range(0, 99)) < tx_idle_pct) begin
      degree_ch.valid <= 1'b0;
      @(posedge clk);
    end
    degree_ch.valid  <= 1'b1;
    degree_ch.degree <= degree;
    @(posedge clk);
    while (!degree_ch.ready) @(posedge clk);
    board.note_degree(degree);
  endtask

  task automatic send_run(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_degree(seq_buf[i]);
  endtask

  // only while idle: all verdicts in, then a settling wait for the last loads
  task automatic write_length(input logic [NUM_VERTICES_W-1:0] value);
    degree_ch.valid <= 1'b0;
    while (board.verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_length(value);
  endtask

  function automatic void build_sequence(int unsigned n, seq_shape_t shape);
    int unsigned top;
    top = n - 1;
    if (shape == SHAPE_NOISE) begin
      for (int unsigned i = 0; i < n; i++) begin
        if ($urandom_range(0, 1) != 0) seq_buf[i] = DEGREE_W'($urandom_range(0, 63));
        else seq_buf[i] = DEGREE_W'($urandom_range(0, n - 1));
      end
      return;
    end
    for (int unsigned i = 0; i < n / 2; i++) begin
      if (shape == SHAPE_MIRRORED) begin
        seq_buf[i] = DEGREE_W'($urandom_range(0, n - 1));
      end else begin
        if (i == 0 || $urandom_range(0, 2) == 0) top = $urandom_range(n / 2, top);
        seq_buf[i] = DEGREE_W'(top);
      end
      seq_buf[n - 1 - i] = DEGREE_W'(n - 1 - seq_buf[i]);
    end
    if (n % 2) seq_buf[n / 2] = DEGREE_W'((n - 1) / 2);
    if (shape == SHAPE_DAMAGED) seq_buf[$urandom_range(0, n - 1)] = DEGREE_W'($urandom_range(0, 63));
  endfunction

  function automatic seq_shape_t pick_shape();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 60) return SHAPE_SORTED;
    if (r < 75) return SHAPE_MIRRORED;
    if (r < 88) return SHAPE_DAMAGED;
    return SHAPE_NOISE;
  endfunction

  initial begin : stimulus
    int unsigned               directed[20] = '{2, 2, 1, 1,  3, 3, 0, 0,  3, 3, 3, 3,
                                                63, 0, 63, 0,  0, 1, 2, 3};
    logic [NUM_VERTICES_W-1:0] len_val;
    int unsigned               n;
    int unsigned               sent;
    int unsigned               runs;
    int unsigned               seqs;
    int unsigned               big_left;
    int unsigned               part;
    int                        r;

    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    degree_ch.valid  <= 1'b0;
    degree_ch.degree <= '0;
    tx_idle_pct      <= 9;
    rx_idle_pct      <= 78;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset length 4: ok, inequality fails, asymmetric, extreme degrees, unsorted
    foreach (directed[i]) send_degree(DEGREE_W'(directed[i]));
    // length 3: symmetric with odd sum
    write_length(NUM_VERTICES_W'(3));
    send_degree(DEGREE_W'(2));
    send_degree(DEGREE_W'(1));
    send_degree(DEGREE_W'(0));
    // partial sequence dropped by a length write; zero acts as one
    send_degree(DEGREE_W'(2));
    write_length(NUM_VERTICES_W'(0));
    send_degree(DEGREE_W'(0));
    send_degree(DEGREE_W'(63));

    sent     = 0;
    runs     = 0;
    big_left = 2;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct <= 9;
          rx_idle_pct <= 78;
        end
        1: begin
          tx_idle_pct <= 78;
          rx_idle_pct <= 9;
        end
        default: begin
          tx_idle_pct <= 0;
          rx_idle_pct <= 0;
        end
      endcase
      if (phase == 2) begin
        // long receiver stall while short sequences keep coming
        write_length(NUM_VERTICES_W'(2));
        hold_requests <= hold_requests + 1;
        for (int s = 0; s < 20; s++) begin
          build_sequence(2, pick_shape());
          send_run(2);
          sent += 2;
        end
      end
      while (sent < (phase + 1) * RANDOM_ITEMS / 3) begin
        r = int'($urandom_range(0, 99));
        if (runs == 0) len_val = NUM_VERTICES_W'(127);
        else if (runs == 1) len_val = NUM_VERTICES_W'(64);
        else if (runs == 2) len_val = NUM_VERTICES_W'(1);
        else if (r < 2 && big_left > 0) begin
          big_left--;
          len_val = NUM_VERTICES_W'($urandom_range(64, 127));
        end else if (r < 14) len_val = NUM_VERTICES_W'($urandom_range(13, 40));
        else len_val = NUM_VERTICES_W'($urandom_range(0, 12));
        write_length(len_val);
        n    = board.sequence_length();
        seqs = (n > 40) ? 1 : $urandom_range(2, 6);
        for (int unsigned s = 0; s < seqs; s++) begin
          build_sequence(n, pick_shape());
          send_run(n);
          sent += n;
        end
        if (n > 1 && $urandom_range(0, 4) == 0) begin
          build_sequence(n, pick_shape());
          part = $urandom_range(1, n - 1);
          send_run(part);
          sent += part;
        end
        runs++;
      end
    end

    degree_ch.valid <= 1'b0;
    while (board.verdicts_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/dsgc_pkg.sv
rtl/dsgc_stream_if.sv
rtl/dsgc_datapath.sv
rtl/dsgc_controller.sv
rtl/degree_sequence_graphic_check.sv
rtl/dsgc_checker.sv
verif/tb.sv
